### rtl/adsr_pkg.sv
package adsr_pkg;

    localparam int          DEF_VOICES = 8;
    localparam logic [15:0] FULL_SCALE = 16'd32768;
    localparam logic [15:0] COUNT_MAX  = 16'hffff;

    // register indexes, byte address bits [3:2]
    localparam logic [1:0] REG_ATTACK  = 2'd0;
    localparam logic [1:0] REG_DECAY   = 2'd1;
    localparam logic [1:0] REG_SUSTAIN = 2'd2;
    localparam logic [1:0] REG_RELEASE = 2'd3;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_NOTE_ON  = 2'd1,
        OP_NOTE_OFF = 2'd2,
        OP_NOP      = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_ATTACK  = 3'd1,
        ST_DECAY   = 3'd2,
        ST_SUSTAIN = 3'd3,
        ST_RELEASE = 3'd4
    } stage_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_READ,
        FSM_MUL,
        FSM_DIV,
        FSM_WB
    } fsm_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [2:0] voice;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  voice_out;
        logic [15:0] level;
        logic [2:0]  stage_out;
        logic        active;
    } result_t;

    // one voice entry as held in the state RAM
    typedef struct packed {
        stage_t      stage;
        logic [15:0] count;
        logic [15:0] level;
        logic [15:0] rel_start;
    } entry_t;

endpackage

### rtl/adsr_ram.sv
module adsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/adsr_envelope_bank.sv
// Bank of linear ADSR envelopes, one entry per voice, sharing one register set.
// Command channel: a command (opcode, voice) is taken on a rising edge with
// start high and busy low. Opcodes: tick advances the voice one sample,
// note on enters attack, note off moves attack/decay/sustain to release.
// Result channel: done is high for exactly one cycle with the voice's state
// after the command on result; the receiver cannot stall it.
// Sequence after the accepting edge: a voice index out of range goes straight to
// the write-back state, where done is raised; other commands read the voice's
// entry and then write back, and a tick that interpolates the level also passes
// a multiply state and a 16-step restoring divider, one quotient bit per cycle.
// busy stays high through the cycle in which done is high, so one command is in
// flight at a time. Per-voice state sits in one RAM with registered read;
// a valid bit per voice makes unwritten entries read as idle/zero.
// Reset: all voices idle at level zero, registers attack/decay/release 0,
// sustain full scale. Configure over APB only while busy is low.
module adsr_envelope_bank #(
    parameter int VOICES = adsr_pkg::DEF_VOICES
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  adsr_pkg::cmd_t   cmd,
    output logic             done,
    output adsr_pkg::result_t result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    import adsr_pkg::*;

    localparam int AW = (VOICES > 1) ? $clog2(VOICES) : 1;

    fsm_t             state_reg, state_next;
    op_t              op_reg;
    logic [2:0]       voice_reg;
    logic [AW-1:0]    addr_reg;
    logic             wr_en_reg;
    entry_t           entry_reg, entry_next;
    logic [15:0]      mul_a_reg, mul_a_next;
    logic [15:0]      mul_b_reg, mul_b_next;
    logic [15:0]      div_reg, div_next;
    logic             sub_reg, sub_next;
    logic [15:0]      rem_reg, rem_next;
    logic [15:0]      quo_reg, quo_next;
    logic [3:0]       iter_reg, iter_next;
    logic [VOICES-1:0] valid_reg;

    logic [15:0]      attack_reg, decay_reg, sustain_reg, release_reg;

    logic             accept;
    logic             in_range;
    logic [AW-1:0]    rd_addr;
    logic [$bits(entry_t)-1:0] ram_rdata;
    entry_t           cur;
    logic [15:0]      sus_q;
    logic [15:0]      n_cnt;
    logic [31:0]      prod;
    logic [16:0]      trial;
    logic             take;
    logic [15:0]      q_new;
    logic             ram_we;
    logic             cfg_wr;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= '0;
            decay_reg   <= '0;
            sustain_reg <= FULL_SCALE;
            release_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_ATTACK:  attack_reg  <= pwdata[15:0];
                REG_DECAY:   decay_reg   <= pwdata[15:0];
                REG_SUSTAIN: sustain_reg <= pwdata[15:0];
                REG_RELEASE: release_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_ATTACK:  prdata = {16'd0, attack_reg};
            REG_DECAY:   prdata = {16'd0, decay_reg};
            REG_SUSTAIN: prdata = {16'd0, sustain_reg};
            REG_RELEASE: prdata = {16'd0, release_reg};
            default:     prdata = '0;
        endcase
    end

    // ---------------- state memory ----------------
    assign accept   = start && !busy;
    assign in_range = 32'(cmd.voice) < VOICES;
    assign rd_addr  = AW'(cmd.voice);
    assign ram_we   = (state_reg == FSM_WB) && wr_en_reg;

    adsr_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (VOICES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (entry_reg),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // never-written voices read as the reset entry
    assign cur   = valid_reg[addr_reg] ? entry_t'(ram_rdata) : '0;
    assign sus_q = (sustain_reg > FULL_SCALE) ? FULL_SCALE : sustain_reg;
    assign n_cnt = (cur.count == COUNT_MAX) ? cur.count : cur.count + 16'd1;

    assign prod  = 32'(mul_a_reg) * 32'(mul_b_reg);
    assign trial = {rem_reg, quo_reg[15]};
    assign take  = trial >= {1'b0, div_reg};
    assign q_new = {quo_reg[14:0], take};

    // ---------------- control ----------------
    always_comb
    begin
        state_next = state_reg;
        entry_next = entry_reg;
        mul_a_next = mul_a_reg;
        mul_b_next = mul_b_reg;
        div_next   = div_reg;
        sub_next   = sub_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        iter_next  = iter_reg;

        case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    entry_next = '0;
                    state_next = in_range ? FSM_READ : FSM_WB;
                end
            end

            FSM_READ:
            begin
                entry_next = cur;
                state_next = FSM_WB;
                case (op_reg)
                    OP_TICK:
                    begin
                        if (cur.stage != ST_IDLE)
                        begin
                            entry_next.count = n_cnt;
                            case (cur.stage)
                                ST_ATTACK:
                                begin
                                    if (attack_reg == 16'd0 || n_cnt >= attack_reg)
                                    begin
                                        entry_next.stage = ST_DECAY;
                                        entry_next.count = '0;
                                        entry_next.level = FULL_SCALE;
                                    end
                                    else
                                    begin
                                        mul_a_next = n_cnt;
                                        mul_b_next = FULL_SCALE;
                                        div_next   = attack_reg;
                                        sub_next   = 1'b0;
                                        state_next = FSM_MUL;
                                    end
                                end
                                ST_DECAY:
                                begin
                                    if (decay_reg == 16'd0 || n_cnt >= decay_reg)
                                    begin
                                        entry_next.stage = ST_SUSTAIN;
                                        entry_next.count = '0;
                                        entry_next.level = sus_q;
                                    end
                                    else
                                    begin
                                        mul_a_next = FULL_SCALE - sus_q;
                                        mul_b_next = n_cnt;
                                        div_next   = decay_reg;
                                        sub_next   = 1'b1;
                                        state_next = FSM_MUL;
                                    end
                                end
                                ST_SUSTAIN:
                                begin
                                    entry_next.level = sus_q;
                                end
                                ST_RELEASE:
                                begin
                                    if (release_reg == 16'd0 || n_cnt >= release_reg)
                                    begin
                                        entry_next.stage = ST_IDLE;
                                        entry_next.level = '0;
                                    end
                                    else
                                    begin
                                        mul_a_next = cur.rel_start;
                                        mul_b_next = release_reg - n_cnt;
                                        div_next   = release_reg;
                                        sub_next   = 1'b0;
                                        state_next = FSM_MUL;
                                    end
                                end
                                default:
                                begin
                                    entry_next.stage = ST_IDLE;
                                end
                            endcase
                        end
                    end
                    OP_NOTE_ON:
                    begin
                        entry_next.stage = ST_ATTACK;
                        entry_next.count = '0;
                    end
                    OP_NOTE_OFF:
                    begin
                        if (cur.stage inside {ST_ATTACK, ST_DECAY, ST_SUSTAIN})
                        begin
                            entry_next.stage     = ST_RELEASE;
                            entry_next.count     = '0;
                            entry_next.rel_start = cur.level;
                        end
                    end
                    default: ;
                endcase
            end

            FSM_MUL:
            begin
                // quotient < 2^15, so the high half is already below the divisor
                rem_next   = prod[31:16];
                quo_next   = prod[15:0];
                iter_next  = '0;
                state_next = FSM_DIV;
            end

            FSM_DIV:
            begin
                rem_next  = take ? 16'(trial - {1'b0, div_reg}) : trial[15:0];
                quo_next  = q_new;
                iter_next = iter_reg + 4'd1;
                if (iter_reg == 4'd15)
                begin
                    entry_next.level = sub_reg ? FULL_SCALE - q_new : q_new;
                    state_next       = FSM_WB;
                end
            end

            FSM_WB:
            begin
                state_next = FSM_IDLE;
            end

            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
            valid_reg <= '0;
            wr_en_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                wr_en_reg <= in_range;
            end
            if (ram_we)
            begin
                valid_reg[addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op_t'(cmd.opcode);
            voice_reg <= cmd.voice;
            addr_reg  <= rd_addr;
        end
        entry_reg <= entry_next;
        mul_a_reg <= mul_a_next;
        mul_b_reg <= mul_b_next;
        div_reg   <= div_next;
        sub_reg   <= sub_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        iter_reg  <= iter_next;
    end

    // ---------------- result ----------------
    assign busy             = state_reg != FSM_IDLE;
    assign done             = state_reg == FSM_WB;
    assign result.voice_out = voice_reg;
    assign result.level     = entry_reg.level;
    assign result.stage_out = entry_reg.stage;
    assign result.active    = entry_reg.stage != ST_IDLE;

    // ---------------- assertions ----------------
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after command transfer");

    a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy && !done)
        else $error("busy or done held after result transfer");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.level <= FULL_SCALE)
        else $error("level above full scale");

    a_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        done && !(32'(result.voice_out) < VOICES) |->
            result.level == 16'd0 && !result.active)
        else $error("out-of-range voice reported nonzero state");

    a_no_write_oor: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !in_range |=> !wr_en_reg)
        else $error("write enabled for out-of-range voice");

endmodule
